### rtl/spsq_pkg.sv
// Package for the stable sorted priority queue.
// Holds payload structs, command and status codes, and the cell entry type.
// No dependencies.
package spsq_pkg;

  localparam int DEPTH_DEFAULT = 16;
  localparam int TAG_W = 16;
  localparam int PRIO_W = 8;
  localparam int OCC_W = 5;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_SERVE = 1'b1;

  localparam logic [1:0] ST_INSERTED = 2'd0;
  localparam logic [1:0] ST_SERVED = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_FULL = 2'd3;

  typedef struct packed {
    logic              command;
    logic [TAG_W-1:0]  tag;
    logic [PRIO_W-1:0] priority_req;
  } in_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [TAG_W-1:0]  served_tag;
    logic [PRIO_W-1:0] served_priority;
    logic [OCC_W-1:0]  occupancy;
  } out_t;

  typedef struct packed {
    logic              valid;
    logic [TAG_W-1:0]  tag;
    logic [PRIO_W-1:0] prio;
  } entry_t;

  // Broadcast to every cell in the chain for one transaction.
  typedef struct packed {
    logic              insert;
    logic              serve;
    logic [TAG_W-1:0]  new_tag;
    logic [PRIO_W-1:0] new_prio;
  } cell_ctrl_t;

endpackage

### rtl/spsq_cell.sv
// One slot of the sorted chain: holds an entry and trades it with its neighbors.
// Depends on spsq_pkg.
module spsq_cell
  import spsq_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cell_ctrl_t ctrl,
  input  entry_t     left,
  input  logic       left_displaced,
  input  entry_t     right,
  output entry_t     slot,
  output logic       displaced
);

  logic              valid;
  logic [TAG_W-1:0]  tag;
  logic [PRIO_W-1:0] prio;

  assign slot = '{valid: valid, tag: tag, prio: prio};

  // The new entry goes after every held entry of lower or equal priority,
  // so this cell gives way when it is empty or holds a strictly larger value.
  assign displaced = !valid || (prio > ctrl.new_prio);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.insert && displaced) begin
      valid <= left_displaced ? left.valid : 1'b1;
    end else if (ctrl.serve) begin
      valid <= right.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.insert && displaced) begin
      if (left_displaced) begin
        tag  <= left.tag;
        prio <= left.prio;
      end else begin
        tag  <= ctrl.new_tag;
        prio <= ctrl.new_prio;
      end
    end else if (ctrl.serve) begin
      tag  <= right.tag;
      prio <= right.prio;
    end
  end

endmodule

### rtl/stable_sorted_priority_queue_top.sv
// Stable sorted priority queue: a chain of DEPTH cells kept in ascending priority order.
// The result of an accepted transaction is registered into the output register.
// One insert or serve per cycle unless out_ready stalls; all cells update in parallel.
// Reset clears all slot valid bits, the occupancy count and the output valid flag.
// Depends on spsq_pkg and spsq_cell.
module stable_sorted_priority_queue_top
  import spsq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t       slots [DEPTH];
  logic         disp  [DEPTH];
  cell_ctrl_t   ctrl;
  logic         accept;
  logic         full;
  logic         empty;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  out_t         result;

  assign in_ready = !out_valid || out_ready;
  assign accept = in_valid && in_ready;
  assign full = slots[DEPTH-1].valid;
  assign empty = !slots[0].valid;

  assign ctrl.insert = accept && (in_data.command == CMD_INSERT) && !full;
  assign ctrl.serve = accept && (in_data.command == CMD_SERVE) && !empty;
  assign ctrl.new_tag = in_data.tag;
  assign ctrl.new_prio = in_data.priority_req;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    entry_t left_e;
    entry_t right_e;
    logic   left_d;

    if (i == 0) begin : g_head
      assign left_e = '0;
      assign left_d = 1'b0;
    end else begin : g_mid
      assign left_e = slots[i-1];
      assign left_d = disp[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_e = '0;
    end else begin : g_body
      assign right_e = slots[i+1];
    end

    spsq_cell u_cell (
      .clk            (clk),
      .rst            (rst),
      .ctrl           (ctrl),
      .left           (left_e),
      .left_displaced (left_d),
      .right          (right_e),
      .slot           (slots[i]),
      .displaced      (disp[i])
    );
  end

  always_comb begin
    count_next = count;
    result = '0;
    if (in_data.command == CMD_INSERT) begin
      if (full) begin
        result.status = ST_FULL;
      end else begin
        result.status = ST_INSERTED;
        count_next = count + CNT_W'(1);
      end
    end else begin
      if (empty) begin
        result.status = ST_EMPTY;
      end else begin
        result.status = ST_SERVED;
        result.served_tag = slots[0].tag;
        result.served_priority = slots[0].prio;
        count_next = count - CNT_W'(1);
      end
    end
    result.occupancy = OCC_W'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= result;
    end
  end

endmodule
